// ===== rtl/core/mlp_pkg.sv =====
// shared constants, types and arithmetic helpers for the 2-2-1 perceptron trainer
package mlp_pkg;

  localparam int FracBits = 16;
  localparam int SigDepth = 256;
  localparam int SigIdxW  = 8;
  localparam int SigEntW  = 17;

  localparam logic signed [31:0] OneQ    = 32'sd65536;
  localparam logic [15:0]        LrReset = 16'd655;

  typedef logic [SigEntW-1:0] sig_tab_t [SigDepth];

  // restoring division, elaboration only (table build)
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid at bin centres, exp(-|x|) by series of |x|/16 squared four times
  function automatic sig_tab_t build_sig_table();
    sig_tab_t   tab;
    logic signed [63:0] num2;
    logic signed [63:0] s;
    logic [63:0] n, t, u, term, e, den, numer;
    logic        pos;
    for (int i = 0; i < SigDepth; i++) begin
      num2 = 64'(32 * i + 16 - 16 * SigDepth);
      pos  = (num2 >= 0);
      n    = pos ? 64'(num2) : 64'(-num2);
      t    = (n << 30) >> 9;
      u    = t >> 4;
      term = 64'd1 << 30;
      s    = 64'sd1 <<< 30;
      for (int k = 1; k <= 12; k++) begin
        term = div_u64((term * u) >> 30, 64'(k));
        if ((k % 2) == 1) s = s - $signed(term);
        else s = s + $signed(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      e = 64'(s);
      for (int r = 0; r < 4; r++) e = (e * e) >> 30;
      den   = (64'd1 << 30) + e;
      numer = pos ? (64'd1 << 30) : e;
      tab[i] = SigEntW'(div_u64((numer << FracBits) + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTable = build_sig_table();

  // saturate a 34-bit sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // product floor-shifted by the fraction width, then saturated
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] r;
    r = 48'(p >>> FracBits);
    if (r[47:31] == '0 || r[47:31] == '1) return r[31:0];
    return r[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // table index for argument z over [-8,8)
  function automatic logic [SigIdxW-1:0] sig_index(input logic signed [31:0] z);
    logic signed [32:0] off;
    off = 33'(z) + 33'sd524288;
    if (off[32]) return '0;
    if (off[31:20] != '0) return '1;
    return off[19:12];
  endfunction

  // saturating difference
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

endpackage

// ===== rtl/core/mlp_2_2_1_sgd_train_step.sv =====
// 2-2-1 sigmoid perceptron, forward pass and one gradient step per word
// Result: the result word and out_valid_o are registered at the prediction step.
// Sequencing: a new word is taken only once the 25-step sequence on the one shared
// 32x32 multiplier is done; the result step waits while an earlier result is unread.
// Reset: weights and biases return to 1.0, step size to 655, the block goes idle.
// The sigmoid table is a constant built at elaboration.
module mlp_2_2_1_sgd_train_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] feature_a_i,
  input  logic [15:0] feature_b_i,
  input  logic        target_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] prediction_o,
  output logic signed [16:0] sample_error_o
);
  import mlp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // sequence steps
  localparam logic [4:0] SH0M0 = 5'd0,  SH0M1 = 5'd1,  SH1M0 = 5'd2,  SH1M1 = 5'd3;
  localparam logic [4:0] SOM0  = 5'd4,  SAct1 = 5'd5,  SOM1  = 5'd6,  SOSum = 5'd7;
  localparam logic [4:0] SPred = 5'd8,  SGrad = 5'd9,  SBo   = 5'd10, SGa0  = 5'd11;
  localparam logic [4:0] SGa1  = 5'd12, SWo1  = 5'd13, SDer0 = 5'd14, SGw0  = 5'd15;
  localparam logic [4:0] SDer1 = 5'd16, SD0   = 5'd17, SB0   = 5'd18, SW0   = 5'd19;
  localparam logic [4:0] SW2   = 5'd20, SD1   = 5'd21, SB1   = 5'd22, SW1   = 5'd23;
  localparam logic [4:0] SLast = 5'd24;

  state_e state_q, state_d;
  logic [4:0] step_q;
  logic [15:0] lr_q;
  logic signed [31:0] x0_q, x1_q;
  logic tgt_q;
  logic signed [31:0] w_q [4];
  logic signed [31:0] b_q [2];
  logic signed [31:0] wo_q [2];
  logic signed [31:0] bo_q;
  logic signed [31:0] act0_q, act1_q, pred_q, g_q, d_q, der0_q, der1_q, tmp_q;
  logic signed [33:0] acc_q;
  logic signed [63:0] prod_q;
  logic out_valid_q;
  logic [15:0] pred16_q;
  logic signed [16:0] err16_q;

  logic in_acc, advance;
  logic signed [31:0] qv, acc_sat, sig_v, err_v;
  logic signed [31:0] ma, mb;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign advance    = !(step_q == SPred && out_valid_q);

  assign qv      = qsat(prod_q);
  assign acc_sat = sat34(acc_q);
  assign sig_v   = 32'(SigTable[sig_index(acc_sat)]);
  assign err_v   = sat_sub(pred_q, tgt_q ? OneQ : 32'sd0);

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      SH0M0: begin ma = x0_q;   mb = w_q[0]; end
      SH0M1: begin ma = x1_q;   mb = w_q[2]; end
      SH1M0: begin ma = x0_q;   mb = w_q[1]; end
      SH1M1: begin ma = x1_q;   mb = w_q[3]; end
      SOM0:  begin ma = act0_q; mb = wo_q[0]; end
      SOM1:  begin ma = act1_q; mb = wo_q[1]; end
      SGrad: begin ma = {16'b0, lr_q}; mb = err_v; end
      SGa0:  begin ma = g_q;    mb = act0_q; end
      SGa1:  begin ma = g_q;    mb = act1_q; end
      SWo1:  begin ma = act0_q; mb = OneQ - act0_q; end
      SDer0: begin ma = g_q;    mb = wo_q[0]; end
      SGw0:  begin ma = act1_q; mb = OneQ - act1_q; end
      SDer1: begin ma = tmp_q;  mb = der0_q; end
      SD0:   begin ma = g_q;    mb = wo_q[1]; end
      SB0:   begin ma = d_q;    mb = x0_q; end
      SW0:   begin ma = d_q;    mb = x1_q; end
      SW2:   begin ma = tmp_q;  mb = der1_q; end
      SB1:   begin ma = d_q;    mb = x0_q; end
      SW1:   begin ma = d_q;    mb = x1_q; end
      default: begin ma = '0;   mb = '0; end
    endcase
  end

  // state sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (step_q == SLast) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      lr_q    <= LrReset;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) w_q[i] <= OneQ;
      b_q[0]  <= OneQ;
      b_q[1]  <= OneQ;
      wo_q[0] <= OneQ;
      wo_q[1] <= OneQ;
      bo_q    <= OneQ;
    end else begin
      if (cfg_we_i) lr_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_IDLE) begin
        step_q <= '0;
      end else if (advance) begin
        state_q <= state_d;
        step_q  <= (step_q == SLast) ? '0 : step_q + 5'd1;
        case (step_q)
          SPred:   out_valid_q <= 1'b1;
          SBo:     bo_q    <= sat_sub(bo_q, qv);
          SGa1:    wo_q[0] <= sat_sub(wo_q[0], qv);
          SWo1:    wo_q[1] <= sat_sub(wo_q[1], qv);
          SB0:     b_q[0]  <= sat_sub(b_q[0], d_q);
          SW0:     w_q[0]  <= sat_sub(w_q[0], qv);
          SW2:     w_q[2]  <= sat_sub(w_q[2], qv);
          SB1:     b_q[1]  <= sat_sub(b_q[1], d_q);
          SW1:     w_q[1]  <= sat_sub(w_q[1], qv);
          SLast:   w_q[3]  <= sat_sub(w_q[3], qv);
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_acc) state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q  <= {16'b0, feature_a_i};
      x1_q  <= {16'b0, feature_b_i};
      tgt_q <= target_i;
    end
    if (state_q == ST_RUN && advance) begin
      prod_q <= ma * mb;
      case (step_q)
        SH0M1: acc_q  <= 34'(b_q[0]) + 34'(qv);
        SH1M0: acc_q  <= acc_q + 34'(qv);
        SH1M1: begin act0_q <= sig_v; acc_q <= 34'(b_q[1]) + 34'(qv); end
        SOM0:  acc_q  <= acc_q + 34'(qv);
        SAct1: begin act1_q <= sig_v; acc_q <= 34'(bo_q) + 34'(qv); end
        SOSum: acc_q  <= acc_q + 34'(qv);
        SPred: begin
          pred_q   <= sig_v;
          pred16_q <= (sig_v[31:16] != '0) ? 16'hffff : sig_v[15:0];
          err16_q  <= ((sig_v[31:16] != '0) ? 17'sh0ffff : {1'b0, sig_v[15:0]})
                      - (tgt_q ? 17'sh10000 : 17'sh00000);
        end
        SBo:   g_q    <= qv;
        SDer0: der0_q <= qv;
        SGw0:  tmp_q  <= qv;
        SDer1: der1_q <= qv;
        SD0:   d_q    <= qv;
        SB0:   tmp_q  <= qv;
        SD1:   d_q    <= qv;
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prediction_o   = pred16_q;
  assign sample_error_o = err16_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> in_stall_o)
    else $error("input taken while a word is in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(bo_q) && $stable(wo_q[0]))
    else $error("output weights moved while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == SPred && out_valid_q && state_q == ST_RUN) |=> (step_q == SPred))
    else $error("result step passed an unread result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == '0) || $past(state_q == ST_RUN))
    else $error("step counter not cleared in idle");
endmodule
